/* rtl/gba_pkg.sv */
`timescale 1ns / 1ps

package gba_pkg;

	localparam int PREF_W  = 24;
	localparam int PROB_W  = 16;
	localparam int SUM_W   = 21;
	localparam int DIV_NW  = 33;
	localparam int DIV_DW  = 32;
	localparam int DIV_CW  = 6;
	localparam int PROD_W  = 50;
	localparam int STEP_W  = 27;

	localparam logic [63:0] EXP_FACTOR = 64'd4034748382;

	localparam logic signed [28:0] PREF_MAX = 29'sd8388607;
	localparam logic signed [28:0] PREF_MIN = -29'sd8388608;

	localparam logic [15:0] STEP_GAIN_RST   = 16'd6554;
	localparam logic [4:0]  ARMS_IN_USE_RST = 5'd10;

	localparam logic REG_STEP_GAIN   = 1'b0;
	localparam logic REG_ARMS_IN_USE = 1'b1;

	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_NO_CHOICE = 1'b1;

	typedef enum logic {
		ACT_CHOOSE = 1'b0,
		ACT_REWARD = 1'b1
	} action_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MAX_RD,
		S_MAX_EX,
		S_EXP_RD,
		S_EXP_IX,
		S_EXP_EX,
		S_DIV,
		S_BASE_DIV,
		S_GAIN,
		S_UPD_RD,
		S_UPD_MUL,
		S_UPD_WR,
		S_PROB_RD,
		S_PROB_EX,
		S_OUT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* rtl/gba_div.sv */
`timescale 1ns / 1ps

module gba_div import gba_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output div_stat_t         stat,
	output logic [DIV_NW-1:0] quo
);

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_NW-1:0] num_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW+1:0] trial;
	logic              qbit;

	always_comb begin
		trial = {1'b0, rem_q, num_q[DIV_NW-1]} - {2'b00, den_q};
		qbit  = !trial[DIV_DW+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= qbit ? trial[DIV_DW-1:0] : {rem_q[DIV_DW-2:0], num_q[DIV_NW-1]};
			num_q <= {num_q[DIV_NW-2:0], qbit};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = num_q;

endmodule

/* rtl/gba_exp_rom.sv */
`timescale 1ns / 1ps

module gba_exp_rom import gba_pkg::*; #(
	parameter int EXP_TABLE_DEPTH = 256,
	parameter int XW              = 8
) (
	input  logic          clk,
	input  logic [XW-1:0] addr,
	output logic [16:0]   data
);

	typedef logic [16:0] lut_t [EXP_TABLE_DEPTH];

	function automatic lut_t build_lut();
		logic [63:0] v;
		lut_t        t;
		v = 64'd1 << 30;
		for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
			t[i] = 17'((v + 64'd8192) >> 14);
			v    = (v * EXP_FACTOR + (64'd1 << 31)) >> 32;
		end
		return t;
	endfunction

	localparam lut_t LUT = build_lut();

	logic [16:0] data_q;

	always_ff @(posedge clk) begin
		data_q <= LUT[addr];
	end

	assign data = data_q;

endmodule

/* rtl/gradient_bandit_agent.sv */
`timescale 1ns / 1ps

// Gradient bandit agent with softmax arm selection.
// Input stream: s_tuser selects the item kind (0 choose, 1 reward); s_tdata
// carries the uniform draw (Q0.16) and the reward (signed Q8.8).
// Output stream: one transfer per input item with the chosen arm, its
// probability, the current baseline and, on m_tuser, a status flag.
// Configuration: cfg_we/cfg_addr/cfg_data write step gain (0) and arm count (1);
// the user must write only while the block is idle, as the block never checks.
// A choose item makes a max pass and an exp-and-sum pass over the active arms,
// then forms each probability with the serial 33-step divider, one per arm.
// A reward with a pending choice divides once for the baseline, then reads,
// multiplies and writes each arm via the shared multiplier and preference RAM.
// One item is worked on at a time; s_tready is high only between items.
// A finished result sits in the output register, so the next item may be
// accepted while the receiver stalls; the following result then waits.
// Reset clears preferences (per-arm valid bits), baseline, reward count and
// the pending choice, and loads the default configuration.

module gradient_bandit_agent import gba_pkg::*; #(
	parameter int MAX_ARMS        = 16,
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // uniform_draw[15:0], reward_value[31:16]
	input  logic        s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // chosen_arm[3:0], chosen_probability[19:4],
	                               // baseline_now[35:20], zero pad[39:36]
	output logic        m_tuser,   // status_code
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_data
);

	localparam int AW = (MAX_ARMS > 1) ? $clog2(MAX_ARMS) : 1;
	localparam int NW = $clog2(MAX_ARMS + 1);
	localparam int XW = (EXP_TABLE_DEPTH > 1) ? $clog2(EXP_TABLE_DEPTH) : 1;

	state_t state_q, state_d;

	logic [15:0] gain_q;
	logic [4:0]  arms_q;

	logic               acc;
	logic               last;
	logic [15:0]        draw_in;
	logic signed [15:0] rew_in;
	logic [NW-1:0]      n_in;

	logic [NW-1:0]      k_q, n_q;
	logic               pass_q, found_q, pend_q, ovld_q;
	logic [AW-1:0]      pending_q, pick_q;
	logic signed [15:0] base_q, rew_q;
	logic [31:0]        cnt_q, cnt_inc;
	logic [15:0]        draw_q, pp_q;
	logic               diff_neg_q, dneg_q, up_q, in_rng_q;
	logic signed [23:0] m_q;
	logic [SUM_W-1:0]   sum_q, cum_q;
	logic [32:0]        a_q;
	logic [PROD_W-1:0]  prod_q;
	logic [3:0]         res_arm_q, o_arm_q;
	logic [15:0]        res_prob_q, o_prob_q;
	logic signed [15:0] res_base_q, o_base_q;
	logic               res_stat_q, o_stat_q;

	logic signed [23:0] pref_mem [MAX_ARMS];
	logic [MAX_ARMS-1:0] pref_vld_q;
	logic signed [23:0] pref_rd_q, pref_val, pref_wd;
	logic               pref_rv_q, pref_we;
	logic [AW-1:0]      pref_ra, prob_ra;
	logic [15:0]        prob_mem [MAX_ARMS];
	logic [15:0]        prob_rd_q, p_sat;
	logic               prob_we;

	logic               div_start;
	logic [DIV_NW-1:0]  div_num, div_quo;
	logic [DIV_DW-1:0]  div_den;
	div_stat_t          div_stat;

	logic [XW-1:0]      rom_addr;
	logic [16:0]        rom_data, e_val;
	logic signed [24:0] dif;
	logic [11:0]        idx;
	logic               in_rng;

	logic signed [16:0] diff, delta;
	logic [16:0]        mag, dabs, w;
	logic               chosen;
	logic [STEP_W-1:0]  step;
	logic signed [28:0] upd;
	logic [SUM_W-1:0]   cum_n;
	logic               hit;
	logic [AW-1:0]      fin_pick;
	logic [15:0]        fin_p;

	assign acc      = s_tvalid && s_tready;
	assign draw_in  = s_tdata[15:0];
	assign rew_in   = s_tdata[31:16];
	assign last     = (k_q == n_q - NW'(1));
	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		if (arms_q < 5'd2)
			n_in = NW'(2);
		else if (int'(arms_q) > MAX_ARMS)
			n_in = NW'(MAX_ARMS);
		else
			n_in = NW'(arms_q);
	end

	always_comb begin
		cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 32'd1;
		diff    = {rew_in[15], rew_in} - {base_q[15], base_q};
		mag     = diff[16] ? 17'(-diff) : 17'(diff);
		delta   = {rew_q[15], rew_q} - {base_q[15], base_q};
		dabs    = delta[16] ? 17'(-delta) : 17'(delta);
		pref_val = pref_rv_q ? pref_rd_q : '0;
		dif     = {m_q[23], m_q} - {pref_val[23], pref_val};
		idx     = dif[23:12];
		in_rng  = ({20'd0, idx} < 32'(EXP_TABLE_DEPTH));
		rom_addr = idx[XW-1:0];
		e_val   = in_rng_q ? rom_data : 17'd0;
		chosen  = (k_q == NW'(pending_q));
		w       = chosen ? (17'd65536 - {1'b0, prob_rd_q}) : {1'b0, prob_rd_q};
		step    = STEP_W'((prod_q + PROD_W'(24'd8388608)) >> 24);
		upd     = up_q ? ({{5{pref_val[23]}}, pref_val} + {2'b00, step})
		               : ({{5{pref_val[23]}}, pref_val} - {2'b00, step});
		if (upd > PREF_MAX)
			pref_wd = PREF_MAX[23:0];
		else if (upd < PREF_MIN)
			pref_wd = PREF_MIN[23:0];
		else
			pref_wd = upd[23:0];
		p_sat   = (div_quo > DIV_NW'(16'hFFFF)) ? 16'hFFFF : div_quo[15:0];
		cum_n   = cum_q + SUM_W'(p_sat);
		hit     = !found_q && ({5'd0, draw_q} < cum_n);
		fin_pick = (hit || !found_q) ? k_q[AW-1:0] : pick_q;
		fin_p    = (hit || !found_q) ? p_sat : pp_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (s_tuser == ACT_REWARD)
						state_d = pend_q ? S_BASE_DIV : S_OUT;
					else
						state_d = S_MAX_RD;
				end
			end
			S_MAX_RD:   state_d = S_MAX_EX;
			S_MAX_EX:   state_d = last ? S_EXP_RD : S_MAX_RD;
			S_EXP_RD:   state_d = S_EXP_IX;
			S_EXP_IX:   state_d = S_EXP_EX;
			S_EXP_EX:   state_d = pass_q ? S_DIV : S_EXP_RD;
			S_DIV: begin
				if (div_stat.done)
					state_d = last ? S_OUT : S_EXP_RD;
			end
			S_BASE_DIV: begin
				if (div_stat.done)
					state_d = S_GAIN;
			end
			S_GAIN:     state_d = S_UPD_RD;
			S_UPD_RD:   state_d = S_UPD_MUL;
			S_UPD_MUL:  state_d = S_UPD_WR;
			S_UPD_WR:   state_d = last ? S_PROB_RD : S_UPD_RD;
			S_PROB_RD:  state_d = S_PROB_EX;
			S_PROB_EX:  state_d = S_OUT;
			S_OUT: begin
				if (!ovld_q || m_tready)
					state_d = S_IDLE;
			end
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		pref_ra   = k_q[AW-1:0];
		pref_we   = 1'b0;
		prob_ra   = k_q[AW-1:0];
		prob_we   = 1'b0;
		div_start = 1'b0;
		div_num   = {e_val, 16'd0};
		div_den   = DIV_DW'(sum_q);
		case (state_q)
			S_IDLE: begin
				div_start = acc && (s_tuser == ACT_REWARD) && pend_q;
				div_num   = DIV_NW'(mag);
				div_den   = cnt_inc;
			end
			S_EXP_EX:  div_start = pass_q;
			S_DIV:     prob_we   = div_stat.done;
			S_UPD_WR:  pref_we   = 1'b1;
			S_PROB_RD: prob_ra   = pending_q;
			default: begin
			end
		endcase
	end

	gba_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	gba_exp_rom #(
		.EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
		.XW              (XW)
	) u_exp_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	always_ff @(posedge clk) begin
		pref_rd_q <= pref_mem[pref_ra];
		pref_rv_q <= pref_vld_q[pref_ra];
		if (pref_we)
			pref_mem[pref_ra] <= pref_wd;
	end

	always_ff @(posedge clk) begin
		prob_rd_q <= prob_mem[prob_ra];
		if (prob_we)
			prob_mem[k_q[AW-1:0]] <= p_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= STEP_GAIN_RST;
			arms_q <= ARMS_IN_USE_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_STEP_GAIN:   gain_q <= cfg_data;
				REG_ARMS_IN_USE: arms_q <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q        <= '0;
			pass_q     <= 1'b0;
			found_q    <= 1'b0;
			pend_q     <= 1'b0;
			pending_q  <= '0;
			base_q     <= '0;
			cnt_q      <= '0;
			ovld_q     <= 1'b0;
			pref_vld_q <= '0;
		end else begin
			if (state_q == S_OUT && (!ovld_q || m_tready))
				ovld_q <= 1'b1;
			else if (m_tready)
				ovld_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					k_q     <= '0;
					pass_q  <= 1'b0;
					found_q <= 1'b0;
					if (acc && s_tuser == ACT_REWARD && pend_q)
						cnt_q <= cnt_inc;
				end
				S_MAX_EX: k_q <= last ? '0 : k_q + NW'(1);
				S_EXP_EX: begin
					if (!pass_q) begin
						k_q    <= last ? '0 : k_q + NW'(1);
						pass_q <= last;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						if (hit)
							found_q <= 1'b1;
						if (last) begin
							pending_q <= fin_pick;
							pend_q    <= 1'b1;
						end else begin
							k_q <= k_q + NW'(1);
						end
					end
				end
				S_BASE_DIV: begin
					if (div_stat.done)
						base_q <= diff_neg_q ? base_q - div_quo[15:0] : base_q + div_quo[15:0];
				end
				S_GAIN: k_q <= '0;
				S_UPD_WR: begin
					pref_vld_q[pref_ra] <= 1'b1;
					if (!last)
						k_q <= k_q + NW'(1);
				end
				S_PROB_EX: pend_q <= 1'b0;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!ovld_q || m_tready)) begin
			o_arm_q  <= res_arm_q;
			o_prob_q <= res_prob_q;
			o_base_q <= res_base_q;
			o_stat_q <= res_stat_q;
		end
		case (state_q)
			S_IDLE: begin
				n_q        <= n_in;
				draw_q     <= draw_in;
				rew_q      <= rew_in;
				diff_neg_q <= diff[16];
				sum_q      <= '0;
				cum_q      <= '0;
				res_arm_q  <= 4'(pending_q);
				res_prob_q <= 16'd0;
				res_base_q <= base_q;
				res_stat_q <= STATUS_NO_CHOICE;
			end
			S_MAX_EX: begin
				if (k_q == '0 || pref_val > m_q)
					m_q <= pref_val;
			end
			S_EXP_IX: in_rng_q <= in_rng;
			S_EXP_EX: begin
				if (!pass_q)
					sum_q <= sum_q + SUM_W'(e_val);
			end
			S_DIV: begin
				if (div_stat.done) begin
					cum_q <= cum_n;
					if (hit) begin
						pick_q <= k_q[AW-1:0];
						pp_q   <= p_sat;
					end
					res_arm_q  <= 4'(fin_pick);
					res_prob_q <= fin_p;
					res_base_q <= base_q;
					res_stat_q <= STATUS_OK;
				end
			end
			S_GAIN: begin
				a_q    <= 33'(gain_q) * 33'(dabs);
				dneg_q <= delta[16];
			end
			S_UPD_MUL: begin
				prod_q <= ({17'd0, a_q} * {34'd0, w[15:0]})
				          + (w[16] ? ({17'd0, a_q} << 16) : '0);
				up_q   <= chosen ? !dneg_q : dneg_q;
			end
			S_PROB_EX: begin
				res_arm_q  <= 4'(pending_q);
				res_prob_q <= prob_rd_q;
				res_base_q <= base_q;
				res_stat_q <= STATUS_OK;
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = ovld_q;
	assign m_tdata  = {4'd0, o_base_q, o_prob_q, o_arm_q};
	assign m_tuser  = o_stat_q;

`ifndef SYNTHESIS
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_sum_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (sum_q != '0))
		else $error("softmax sum is zero during division");

	a_pick_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pend_q) |-> (NW'(pending_q) < n_q))
		else $error("chosen arm beyond active arms");
`endif

endmodule
